// ----- sv/sedge_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel edge threshold package
// Register indexes, field widths and fixed values shared by the block.
// ----------------------------------------------------------------------------
package sedge_pkg;

   // Widths of the configuration port and of the register fields.
   localparam int CSR_INDEX_BITS = 2;
   localparam int DIM_BITS       = 12;
   localparam int THR_BITS       = 8;
   localparam int OUT_BITS       = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDGE_THRESHOLD = 2'd2;

   // Register values after reset.
   localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET    = 12'd640;
   localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET   = 12'd480;
   localparam logic [THR_BITS-1:0] EDGE_THRESHOLD_RESET = 8'd50;

   // Smallest usable frame dimension.
   localparam int MIN_DIM = 3;

   // Marker values for interior pixels.
   localparam logic [OUT_BITS-1:0] EDGE_VALUE = 8'd255;
   localparam logic [OUT_BITS-1:0] FLAT_VALUE = 8'd0;

endpackage

// ----- sv/sedge_line_store.sv -----
// ----------------------------------------------------------------------------
// Sobel edge line store
// One row of pixels: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sedge_line_store #(
   parameter int DEPTH     = 2048,
   parameter int DATA_BITS = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]     wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_BITS-1:0]     rd_data
);

   logic [DATA_BITS-1:0] mem [0:DEPTH-1];
   logic [DATA_BITS-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sobel_edge_threshold.sv -----
// ----------------------------------------------------------------------------
// Sobel edge threshold
// Streaming 3x3 Sobel edge marker over gray frames in raster order.
// ----------------------------------------------------------------------------
// Usage. Pixels enter on the req channel, one word per pixel in raster order.
// A word with req_drain set carries no pixel and pushes out one delayed pixel
// after the end of a frame. Results leave on the rsp channel: border pixels
// unchanged, interior pixels 255 where dx^2 + dy^2 > 16 * threshold^2 and 0
// elsewhere, with rsp_frame_end on the last pixel of the frame. Each result
// trails its input by one row and one column, so the first result of a frame
// is pushed out by input word W+2 of that frame.
// Throughput is one word per clock while req_ready is high. The two line
// stores each take one read and one write per cycle; a read of the entry
// written in the same cycle is served by a forwarding register. The word that
// pushes a result out passes read, window, squares and output to reach rsp.
// The csr channel is always ready. After reset and after every register
// write a setup pass derives the clamped frame size and threshold and splits
// the output position into row and column with a serial divider, or restarts
// it at zero if it lies past the new frame; req_ready stays low meanwhile.
// Reset clears the window, the counters and the pipeline; the line stores
// are not cleared. When the receiver stalls, the output register holds its
// word and the pipeline fills its empty stages before req_ready drops.
// ----------------------------------------------------------------------------
module sobel_edge_threshold #(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_drain,
   input  logic [PIXEL_BITS-1:0]               req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sedge_pkg::OUT_BITS-1:0]      rsp_pixel_out,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sedge_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sedge_pkg::DIM_BITS-1:0]      csr_data
);

   localparam int CB  = $clog2(MAX_WIDTH);       // column index bits
   localparam int WB  = $clog2(MAX_WIDTH + 1);   // width value bits
   localparam int DB  = sedge_pkg::DIM_BITS;
   localparam int TB  = sedge_pkg::THR_BITS;
   localparam int OB  = sedge_pkg::OUT_BITS;
   localparam int IXB = CB + DB;                 // raster index bits
   localparam int DLB = $clog2(MAX_WIDTH + 3);   // delayed pixel count bits
   localparam int AW  = DLB + 1;                 // address arithmetic bits
   localparam int DXB = PIXEL_BITS + 3;          // signed gradient bits
   localparam int SQB = 2 * DXB;                 // squared gradient bits
   localparam int THQ = 2 * TB + 4;              // 16 * threshold^2 bits
   localparam int STB = $clog2(IXB);             // divider step bits

   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_LAST  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;

   // Registers and their configuration.
   logic [DB-1:0]  frame_width_ff, frame_width_in;
   logic [DB-1:0]  frame_height_ff, frame_height_in;
   logic [TB-1:0]  edge_threshold_ff, edge_threshold_in;
   logic [WB-1:0]  eff_w_ff, eff_w_in;
   logic [DB-1:0]  eff_h_ff, eff_h_in;
   logic [WB-1:0]  w_m1_ff, w_m1_in;
   logic [DB-1:0]  h_m1_ff, h_m1_in;
   logic [THQ-1:0] thr16_ff, thr16_in;
   logic [IXB-1:0] frame_last_ff, frame_last_in;

   // Setup sequencer and serial divider.
   logic [2:0]     state_ff, state_in;
   logic [IXB-1:0] div_num_ff, div_num_in;
   logic [WB-1:0]  div_rem_ff, div_rem_in;
   logic [IXB-1:0] div_quo_ff, div_quo_in;
   logic [STB-1:0] div_step_ff, div_step_in;

   // Stream position.
   logic [CB-1:0]  col_ff, col_in;
   logic [DLB-1:0] delayed_ff, delayed_in;
   logic [IXB-1:0] out_index_ff, out_index_in;
   logic [DB-1:0]  out_row_ff, out_row_in;
   logic [CB-1:0]  out_col_ff, out_col_in;

   logic [PIXEL_BITS-1:0] win_ff [0:2][0:2];
   logic [PIXEL_BITS-1:0] win_in [0:2][0:2];

   // Read stage: the word whose line store data is on the read ports.
   logic                  a_valid_ff, a_valid_in;
   logic                  a_drain_ff, a_drain_in;
   logic                  a_emit_ff, a_emit_in;
   logic                  a_upper_ff, a_upper_in;
   logic [CB-1:0]         a_addr_ff, a_addr_in;
   logic [PIXEL_BITS-1:0] a_px_ff, a_px_in;
   logic                  a_fwd_ff, a_fwd_in;
   logic [PIXEL_BITS-1:0] a_fwd_upper_ff, a_fwd_upper_in;
   logic [PIXEL_BITS-1:0] a_fwd_lower_ff, a_fwd_lower_in;

   // Gradient stage.
   logic                  b_valid_ff, b_valid_in;
   logic [OB-1:0]         b_raw_ff, b_raw_in;
   logic                  b_use_ff, b_use_in;
   logic                  b_end_ff, b_end_in;
   logic signed [DXB-1:0] b_dx_ff, b_dx_in;
   logic signed [DXB-1:0] b_dy_ff, b_dy_in;

   // Square stage.
   logic                  c_valid_ff, c_valid_in;
   logic [OB-1:0]         c_raw_ff, c_raw_in;
   logic                  c_use_ff, c_use_in;
   logic                  c_end_ff, c_end_in;
   logic [SQB-1:0]        c_dx2_ff, c_dx2_in;
   logic [SQB-1:0]        c_dy2_ff, c_dy2_in;

   // Output register.
   logic                  o_valid_ff, o_valid_in;
   logic [OB-1:0]         o_pixel_ff, o_pixel_in;
   logic                  o_end_ff, o_end_in;

   // Combinational signals.
   logic                  o_free, c_free, b_free, a_done, a_free;
   logic                  accept, accept_live;
   logic [AW-1:0]         col_a, w_a, dl_a, back_a, back_mod;
   logic                  data_emit, drain_upper, drain_live;
   logic [CB-1:0]         prev_col, rd_addr;
   logic [PIXEL_BITS-1:0] upper_rd, lower_rd, top_eff, mid_eff, raw_px;
   logic                  wr_en;
   logic signed [DXB-1:0] nw_s, n_s, ne_s, w_s, e_s, sw_s, s_s, se_s;
   logic signed [DXB-1:0] dx, dy;
   logic signed [SQB-1:0] dx2_full, dy2_full;
   logic                  interior, at_last;
   logic [31:0]           fw_wide;
   logic [2*TB-1:0]       thr_sq;
   logic [IXB-1:0]        area;
   logic [WB:0]           rem_sh, rem_nx;
   logic                  rem_ge;
   logic [IXB-1:0]        quo_nx;
   logic [SQB:0]          mag_sum;

   function automatic logic signed [DXB-1:0] px_s(input logic [PIXEL_BITS-1:0] p);
      px_s = $signed({3'b000, p});
   endfunction

   // ---------------------------------------------------------------------
   // Handshake and pipeline flow. A stage moves on when the next one is
   // empty or moving; a word that makes no result leaves the read stage
   // without waiting for the gradient stage.
   // ---------------------------------------------------------------------
   assign o_free = !o_valid_ff || rsp_ready;
   assign c_free = !c_valid_ff || o_free;
   assign b_free = !b_valid_ff || c_free;
   assign a_done = a_valid_ff && (b_free || !a_emit_ff);
   assign a_free = !a_valid_ff || a_done;

   assign req_ready   = a_free && (state_ff == ST_RUN) && !csr_valid;
   assign accept      = req_valid && req_ready;
   assign drain_live  = (delayed_ff != '0);
   // A drain word with nothing delayed is taken and dropped here.
   assign accept_live = accept && (!req_drain || drain_live);
   assign csr_ready   = 1'b1;

   // ---------------------------------------------------------------------
   // Read address. A pixel word reads both stores at its own column. A
   // drain word reads the upper store one column back while more than a
   // row is delayed, and otherwise the lower store at the oldest delayed
   // column.
   // ---------------------------------------------------------------------
   assign col_a       = AW'(col_ff);
   assign w_a         = AW'(eff_w_ff);
   assign dl_a        = AW'(delayed_ff);
   assign data_emit   = (dl_a > w_a);
   assign drain_upper = (dl_a > w_a);
   assign back_a      = col_a + w_a - dl_a;
   assign back_mod    = (back_a >= w_a) ? (back_a - w_a) : back_a;
   assign prev_col    = (col_ff == '0) ? CB'(w_a - AW'(1)) : (col_ff - CB'(1));

   always_comb begin
      if (!req_drain) begin
         rd_addr = col_ff;
      end else if (drain_upper) begin
         rd_addr = prev_col;
      end else begin
         rd_addr = CB'(back_mod);
      end
   end

   // ---------------------------------------------------------------------
   // Line stores. The read stage writes the shifted column back as it
   // leaves; a word accepted in that same cycle at that column takes the
   // written values from the forwarding registers instead of the ports.
   // ---------------------------------------------------------------------
   assign wr_en   = a_done && !a_drain_ff;
   assign top_eff = a_fwd_ff ? a_fwd_upper_ff : upper_rd;
   assign mid_eff = a_fwd_ff ? a_fwd_lower_ff : lower_rd;

   sedge_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (PIXEL_BITS)
   ) u_upper (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (a_addr_ff),
      .wr_data (mid_eff),
      .rd_en   (accept_live),
      .rd_addr (rd_addr),
      .rd_data (upper_rd)
   );

   sedge_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (PIXEL_BITS)
   ) u_lower (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (a_addr_ff),
      .wr_data (a_px_ff),
      .rd_en   (accept_live),
      .rd_addr (rd_addr),
      .rd_data (lower_rd)
   );

   // ---------------------------------------------------------------------
   // Window after the shift, gradients and the position of the result.
   // ---------------------------------------------------------------------
   assign nw_s = px_s(win_ff[0][1]);
   assign n_s  = px_s(win_ff[0][2]);
   assign ne_s = px_s(top_eff);
   assign w_s  = px_s(win_ff[1][1]);
   assign e_s  = px_s(mid_eff);
   assign sw_s = px_s(win_ff[2][1]);
   assign s_s  = px_s(win_ff[2][2]);
   assign se_s = px_s(a_px_ff);

   assign dx = (ne_s - nw_s) + (e_s - w_s) + (e_s - w_s) + (se_s - sw_s);
   assign dy = (sw_s + s_s + s_s + se_s) - (nw_s + n_s + n_s + ne_s);

   // The centre pixel of the shifted window is the one that leaves.
   always_comb begin
      if (a_drain_ff) begin
         raw_px = a_upper_ff ? top_eff : mid_eff;
      end else begin
         raw_px = win_ff[1][2];
      end
   end

   assign interior = !a_drain_ff && (out_row_ff != '0) && (out_row_ff < h_m1_ff) &&
                     (out_col_ff != '0) && (AW'(out_col_ff) < AW'(w_m1_ff));
   assign at_last  = (out_index_ff == frame_last_ff);

   // ---------------------------------------------------------------------
   // Setup arithmetic: clamped size, threshold square, frame area and one
   // step of the restoring divider that splits the output index.
   // ---------------------------------------------------------------------
   assign fw_wide = 32'(frame_width_ff);
   assign thr_sq  = edge_threshold_ff * edge_threshold_ff;
   assign area    = eff_w_ff * eff_h_ff;
   assign rem_sh  = {div_rem_ff, div_num_ff[IXB-1]};
   assign rem_ge  = (rem_sh >= {1'b0, eff_w_ff});
   assign rem_nx  = rem_ge ? (rem_sh - {1'b0, eff_w_ff}) : rem_sh;
   assign quo_nx  = {div_quo_ff[IXB-2:0], rem_ge};

   // ---------------------------------------------------------------------
   // Control: configuration, setup pass and stream counters.
   // ---------------------------------------------------------------------
   always_comb begin
      frame_width_in    = frame_width_ff;
      frame_height_in   = frame_height_ff;
      edge_threshold_in = edge_threshold_ff;
      eff_w_in          = eff_w_ff;
      eff_h_in          = eff_h_ff;
      w_m1_in           = w_m1_ff;
      h_m1_in           = h_m1_ff;
      thr16_in          = thr16_ff;
      frame_last_in     = frame_last_ff;
      state_in          = state_ff;
      div_num_in        = div_num_ff;
      div_rem_in        = div_rem_ff;
      div_quo_in        = div_quo_ff;
      div_step_in       = div_step_ff;
      col_in            = col_ff;
      delayed_in        = delayed_ff;
      out_index_in      = out_index_ff;
      out_row_in        = out_row_ff;
      out_col_in        = out_col_ff;

      if (csr_valid) begin
         case (csr_index)
            sedge_pkg::CSR_FRAME_WIDTH: begin
               frame_width_in = csr_data;
            end
            sedge_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_data;
            end
            sedge_pkg::CSR_EDGE_THRESHOLD: begin
               edge_threshold_in = csr_data[TB-1:0];
            end
            default: begin
            end
         endcase
         state_in = ST_SETUP;
      end else begin
         case (state_ff)
            ST_SETUP: begin
               if (fw_wide < 32'(sedge_pkg::MIN_DIM)) begin
                  eff_w_in = WB'(sedge_pkg::MIN_DIM);
               end else if (fw_wide > 32'(MAX_WIDTH)) begin
                  eff_w_in = WB'(MAX_WIDTH);
               end else begin
                  eff_w_in = WB'(fw_wide);
               end
               if (frame_height_ff < DB'(sedge_pkg::MIN_DIM)) begin
                  eff_h_in = DB'(sedge_pkg::MIN_DIM);
               end else begin
                  eff_h_in = frame_height_ff;
               end
               thr16_in = {thr_sq, 4'b0000};
               state_in = ST_LAST;
            end
            ST_LAST: begin
               frame_last_in = area - IXB'(1);
               w_m1_in       = eff_w_ff - WB'(1);
               h_m1_in       = eff_h_ff - DB'(1);
               if (col_a >= w_a) begin
                  col_in = '0;
               end
               state_in = ST_CHECK;
            end
            ST_CHECK: begin
               if (out_index_ff > frame_last_ff) begin
                  out_index_in = '0;
                  out_row_in   = '0;
                  out_col_in   = '0;
                  state_in     = ST_RUN;
               end else begin
                  div_num_in  = out_index_ff;
                  div_rem_in  = '0;
                  div_quo_in  = '0;
                  div_step_in = '0;
                  state_in    = ST_DIV;
               end
            end
            ST_DIV: begin
               div_num_in  = {div_num_ff[IXB-2:0], 1'b0};
               div_rem_in  = rem_nx[WB-1:0];
               div_quo_in  = quo_nx;
               div_step_in = div_step_ff + STB'(1);
               if (div_step_ff == STB'(IXB - 1)) begin
                  out_col_in = rem_nx[CB-1:0];
                  out_row_in = quo_nx[DB-1:0];
                  state_in   = ST_RUN;
               end
            end
            ST_RUN: begin
               if (accept) begin
                  if (!req_drain) begin
                     col_in = (col_a + AW'(1) >= w_a) ? '0 : (col_ff + CB'(1));
                     delayed_in = data_emit ? DLB'(w_a + AW'(1)) : (delayed_ff + DLB'(1));
                  end else if (drain_live) begin
                     delayed_in = delayed_ff - DLB'(1);
                  end
               end
               if (a_done && a_emit_ff) begin
                  if (at_last) begin
                     out_index_in = '0;
                     out_row_in   = '0;
                     out_col_in   = '0;
                  end else begin
                     out_index_in = out_index_ff + IXB'(1);
                     if (AW'(out_col_ff) == AW'(w_m1_ff)) begin
                        out_col_in = '0;
                        out_row_in = out_row_ff + DB'(1);
                     end else begin
                        out_col_in = out_col_ff + CB'(1);
                     end
                  end
               end
            end
            default: begin
               state_in = ST_SETUP;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline valids and the window.
   // ---------------------------------------------------------------------
   always_comb begin
      if (accept_live) begin
         a_valid_in = 1'b1;
      end else if (a_done) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
      b_valid_in = b_free ? (a_done && a_emit_ff) : b_valid_ff;
      c_valid_in = c_free ? b_valid_ff : c_valid_ff;
      o_valid_in = o_free ? c_valid_ff : o_valid_ff;

      win_in = win_ff;
      if (a_done && !a_drain_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = top_eff;
         win_in[1][2] = mid_eff;
         win_in[2][2] = a_px_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline payload.
   // ---------------------------------------------------------------------
   assign dx2_full = b_dx_ff * b_dx_ff;
   assign dy2_full = b_dy_ff * b_dy_ff;
   assign mag_sum  = (SQB+1)'(c_dx2_ff) + (SQB+1)'(c_dy2_ff);

   always_comb begin
      a_drain_in     = a_drain_ff;
      a_emit_in      = a_emit_ff;
      a_upper_in     = a_upper_ff;
      a_addr_in      = a_addr_ff;
      a_px_in        = a_px_ff;
      a_fwd_in       = a_fwd_ff;
      a_fwd_upper_in = a_fwd_upper_ff;
      a_fwd_lower_in = a_fwd_lower_ff;
      if (accept_live) begin
         a_drain_in     = req_drain;
         a_emit_in      = req_drain || data_emit;
         a_upper_in     = drain_upper;
         a_addr_in      = rd_addr;
         a_px_in        = req_pixel_in;
         a_fwd_in       = a_done && !a_drain_ff && (a_addr_ff == rd_addr);
         a_fwd_upper_in = mid_eff;
         a_fwd_lower_in = a_px_ff;
      end

      b_raw_in = b_raw_ff;
      b_use_in = b_use_ff;
      b_end_in = b_end_ff;
      b_dx_in  = b_dx_ff;
      b_dy_in  = b_dy_ff;
      if (b_free) begin
         b_raw_in = raw_px[OB-1:0];
         b_use_in = interior;
         b_end_in = at_last;
         b_dx_in  = dx;
         b_dy_in  = dy;
      end

      c_raw_in = c_raw_ff;
      c_use_in = c_use_ff;
      c_end_in = c_end_ff;
      c_dx2_in = c_dx2_ff;
      c_dy2_in = c_dy2_ff;
      if (c_free) begin
         c_raw_in = b_raw_ff;
         c_use_in = b_use_ff;
         c_end_in = b_end_ff;
         c_dx2_in = SQB'(dx2_full);
         c_dy2_in = SQB'(dy2_full);
      end

      o_pixel_in = o_pixel_ff;
      o_end_in   = o_end_ff;
      if (o_free) begin
         if (!c_use_ff) begin
            o_pixel_in = c_raw_ff;
         end else if (mag_sum > (SQB+1)'(thr16_ff)) begin
            o_pixel_in = sedge_pkg::EDGE_VALUE;
         end else begin
            o_pixel_in = sedge_pkg::FLAT_VALUE;
         end
         o_end_in = c_end_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= sedge_pkg::FRAME_WIDTH_RESET;
         frame_height_ff   <= sedge_pkg::FRAME_HEIGHT_RESET;
         edge_threshold_ff <= sedge_pkg::EDGE_THRESHOLD_RESET;
         state_ff          <= ST_SETUP;
         col_ff            <= '0;
         delayed_ff        <= '0;
         out_index_ff      <= '0;
         out_row_ff        <= '0;
         out_col_ff        <= '0;
         a_valid_ff        <= 1'b0;
         b_valid_ff        <= 1'b0;
         c_valid_ff        <= 1'b0;
         o_valid_ff        <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[r][k] <= '0;
            end
         end
      end else begin
         frame_width_ff    <= frame_width_in;
         frame_height_ff   <= frame_height_in;
         edge_threshold_ff <= edge_threshold_in;
         state_ff          <= state_in;
         col_ff            <= col_in;
         delayed_ff        <= delayed_in;
         out_index_ff      <= out_index_in;
         out_row_ff        <= out_row_in;
         out_col_ff        <= out_col_in;
         a_valid_ff        <= a_valid_in;
         b_valid_ff        <= b_valid_in;
         c_valid_ff        <= c_valid_in;
         o_valid_ff        <= o_valid_in;
         win_ff            <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      eff_w_ff       <= eff_w_in;
      eff_h_ff       <= eff_h_in;
      w_m1_ff        <= w_m1_in;
      h_m1_ff        <= h_m1_in;
      thr16_ff       <= thr16_in;
      frame_last_ff  <= frame_last_in;
      div_num_ff     <= div_num_in;
      div_rem_ff     <= div_rem_in;
      div_quo_ff     <= div_quo_in;
      div_step_ff    <= div_step_in;
      a_drain_ff     <= a_drain_in;
      a_emit_ff      <= a_emit_in;
      a_upper_ff     <= a_upper_in;
      a_addr_ff      <= a_addr_in;
      a_px_ff        <= a_px_in;
      a_fwd_ff       <= a_fwd_in;
      a_fwd_upper_ff <= a_fwd_upper_in;
      a_fwd_lower_ff <= a_fwd_lower_in;
      b_raw_ff       <= b_raw_in;
      b_use_ff       <= b_use_in;
      b_end_ff       <= b_end_in;
      b_dx_ff        <= b_dx_in;
      b_dy_ff        <= b_dy_in;
      c_raw_ff       <= c_raw_in;
      c_use_ff       <= c_use_in;
      c_end_ff       <= c_end_in;
      c_dx2_ff       <= c_dx2_in;
      c_dy2_ff       <= c_dy2_in;
      o_pixel_ff     <= o_pixel_in;
      o_end_ff       <= o_end_in;
   end

   assign rsp_valid     = o_valid_ff;
   assign rsp_pixel_out = o_pixel_ff;
   assign rsp_frame_end = o_end_ff;

endmodule

// ----- test/sobel_edge_threshold_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge threshold testbench
// Streams gray frames of many sizes through the edge marker and checks every
// result word against a cycle-free predictor of the line stores and window.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_tb;
   import sedge_pkg::*;

   localparam int MAX_WIDTH        = 2048;
   localparam int PIXEL_BITS       = 8;
   // Words pass the read, window, square and output registers; leave a generous margin.
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_WORDS     = 950;
   localparam int MAX_REPORTS      = 30;

   // Directed 3x3 frames. The first has a strong gradient around its center,
   // the second a horizontal ramp whose gradient lands exactly on the limit
   // for a threshold of 255, so the center must stay flat.
   localparam logic [0:8][7:0] SHARP_FRAME = {
      8'd10, 8'd200, 8'd30,
      8'd0,  8'd77,  8'd255,
      8'd40, 8'd90,  8'd20
   };
   localparam logic [0:8][7:0] LIMIT_FRAME = {
      8'd0, 8'd128, 8'd255,
      8'd0, 8'd128, 8'd255,
      8'd0, 8'd128, 8'd255
   };

   typedef struct packed {
      logic                  drain;
      logic [PIXEL_BITS-1:0] pixel;
   } raster_word_t;

   typedef struct packed {
      logic [OUT_BITS-1:0] pixel;
      logic                frame_end;
   } marked_pixel_t;

   typedef enum int {TEXTURE_NOISE, TEXTURE_SMOOTH, TEXTURE_BINARY} texture_t;
   typedef enum int {FLOW_FREE, FLOW_SENDER_GAPS, FLOW_RECEIVER_STALLS, FLOW_BOTH} flow_t;

   // ------------------------------------------------------------------------
   // Block under test and its stimulus signals. Every input has a known value
   // from time zero.
   // ------------------------------------------------------------------------
   logic                        clock        = 1'b0;
   logic                        reset        = 1'b1;
   logic                        req_valid    = 1'b0;
   logic                        req_ready;
   logic                        req_drain    = 1'b0;
   logic [PIXEL_BITS-1:0]       req_pixel_in = '0;
   logic                        rsp_valid;
   logic                        rsp_ready    = 1'b0;
   logic [OUT_BITS-1:0]         rsp_pixel_out;
   logic                        rsp_frame_end;
   logic                        csr_valid    = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index    = CSR_FRAME_WIDTH;
   logic [DIM_BITS-1:0]         csr_data     = '0;

   sobel_edge_threshold uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_drain     (req_drain),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Shared bookkeeping. Counters written at the rising edge are only read
   // at the falling edge, so nothing depends on ordering within a step.
   // ------------------------------------------------------------------------
   raster_word_t  words_to_send [$];
   marked_pixel_t marked_due [$];

   int unsigned words_queued    = 0;
   int unsigned words_accepted  = 0;
   int unsigned results_checked = 0;
   int unsigned frames_seen     = 0;
   int unsigned mismatch_count  = 0;
   int          send_idle_pct   = 0;
   int          rsp_stall_pct   = 0;
   int          gen_frame_pos   = 0;

   // A long receiver hold-off is requested by bumping hold_requests; the
   // receiver process counts the cycles itself.
   int          hold_requests   = 0;
   int          hold_served     = 0;
   int          hold_length     = 0;
   int          rsp_hold_left   = 0;

   logic        req_fired       = 1'b0;
   logic        csr_fired       = 1'b0;

   // ------------------------------------------------------------------------
   // Predictor state: registers, two line stores, 3x3 window and counters.
   // ------------------------------------------------------------------------
   logic [DIM_BITS-1:0]   model_width     = FRAME_WIDTH_RESET;
   logic [DIM_BITS-1:0]   model_height    = FRAME_HEIGHT_RESET;
   logic [THR_BITS-1:0]   model_threshold = EDGE_THRESHOLD_RESET;
   logic [PIXEL_BITS-1:0] upper_row [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] lower_row [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] window [3][3];
   int unsigned           in_col;
   int unsigned           in_row;
   int unsigned           out_pos;
   int unsigned           held_pixels;

   // Width and height as the block uses them, after clamping.
   function automatic int unsigned active_width();
      int unsigned w;
      w = model_width;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned active_height();
      return (model_height < MIN_DIM) ? MIN_DIM : model_height;
   endfunction

   function automatic void write_model_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                                           input logic [DIM_BITS-1:0] val);
      case (idx)
         CSR_FRAME_WIDTH:    model_width = val;
         CSR_FRAME_HEIGHT:   model_height = val;
         CSR_EDGE_THRESHOLD: model_threshold = val[THR_BITS-1:0];
         default: ;
      endcase
   endfunction

   // Produces the word for raster position out_pos. Interior pixels pushed
   // out by a data word are marked from the window; everything else passes
   // the delayed gray value through.
   function automatic marked_pixel_t emit_pixel(input logic [PIXEL_BITS-1:0] raw,
                                                input bit use_window);
      int unsigned   w, h, last, orow, ocol;
      int            nw, n, ne, wl, e, sw, s, se, gx, gy, thr;
      marked_pixel_t res;
      w    = active_width();
      h    = active_height();
      last = w * h - 1;
      orow = out_pos / w;
      ocol = out_pos % w;
      res.pixel = raw;
      if (use_window && orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w) begin
         nw  = window[0][0];
         n   = window[0][1];
         ne  = window[0][2];
         wl  = window[1][0];
         e   = window[1][2];
         sw  = window[2][0];
         s   = window[2][1];
         se  = window[2][2];
         gx  = ne - nw + 2 * (e - wl) + se - sw;
         gy  = sw + 2 * s + se - nw - 2 * n - ne;
         thr = model_threshold;
         res.pixel = (gx * gx + gy * gy > 16 * thr * thr) ? EDGE_VALUE : FLAT_VALUE;
      end
      res.frame_end = (out_pos >= last);
      out_pos = (out_pos >= last) ? 0 : out_pos + 1;
      return res;
   endfunction

   // Advances the predictor by one accepted word; returns 1 when it pushes
   // out a result.
   function automatic bit accept_raster_word(input raster_word_t word,
                                             output marked_pixel_t res);
      int unsigned           w, h, c;
      int                    r;
      logic [PIXEL_BITS-1:0] top, mid, raw;
      w = active_width();
      h = active_height();
      res = '0;
      if (in_col >= w) in_col = 0;
      if (in_row >= h) in_row = 0;
      if (out_pos > w * h - 1) out_pos = 0;
      c = in_col;

      if (word.drain) begin
         if (held_pixels == 0) return 1'b0;
         if (held_pixels > w) raw = upper_row[(c + w - 1) % w];
         else raw = lower_row[(c + w - held_pixels) % w];
         held_pixels--;
         res = emit_pixel(raw, 1'b0);
         return 1'b1;
      end

      top = upper_row[c];
      mid = lower_row[c];
      upper_row[c] = mid;
      lower_row[c] = word.pixel;

      raw = window[1][2];
      for (r = 0; r < 3; r++) begin
         window[r][0] = window[r][1];
         window[r][1] = window[r][2];
      end
      window[0][2] = top;
      window[1][2] = mid;
      window[2][2] = word.pixel;

      if (in_col + 1 >= w) begin
         in_col = 0;
         in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
      end else begin
         in_col++;
      end

      held_pixels++;
      if (held_pixels > w + 1) begin
         held_pixels = w + 1;
         res = emit_pixel(raw, 1'b1);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string field, input logic [7:0] want,
                                  input logic [7:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // ------------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge. A result is checked
   // before the word accepted at the same edge is predicted, since that word
   // cannot have produced it yet.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      marked_pixel_t predicted, oldest;
      raster_word_t  arrived;
      bit            produced;
      int            i;
      if (reset) begin
         req_fired <= 1'b0;
         csr_fired <= 1'b0;
         model_width     = FRAME_WIDTH_RESET;
         model_height    = FRAME_HEIGHT_RESET;
         model_threshold = EDGE_THRESHOLD_RESET;
         for (i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i] = '0;
            lower_row[i] = '0;
         end
         for (i = 0; i < 9; i++) window[i / 3][i % 3] = '0;
         in_col      = 0;
         in_row      = 0;
         out_pos     = 0;
         held_pixels = 0;
      end else begin
         req_fired <= req_valid && req_ready;
         csr_fired <= csr_valid && csr_ready;

         if (rsp_valid && rsp_ready) begin
            if (marked_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: result with none outstanding, expected none, actual %0d/%0d",
                           $time, rsp_pixel_out, rsp_frame_end);
            end else begin
               oldest = marked_due.pop_front();
               if (oldest.pixel !== rsp_pixel_out)
                  report_mismatch("pixel_out", oldest.pixel, rsp_pixel_out);
               if (oldest.frame_end !== rsp_frame_end)
                  report_mismatch("frame_end", oldest.frame_end, rsp_frame_end);
               results_checked++;
               if (rsp_frame_end === 1'b1) frames_seen++;
            end
         end

         if (csr_valid && csr_ready) write_model_reg(csr_index, csr_data);

         if (req_valid && req_ready) begin
            arrived.drain = req_drain;
            arrived.pixel = req_pixel_in;
            produced = accept_raster_word(arrived, predicted);
            if (produced) marked_due.push_back(predicted);
            words_accepted++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driver: at the falling edge, once the current word has been taken (or
   // none is up), offer the next pending word or idle at random.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : driver
      raster_word_t word;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            word = words_to_send.pop_front();
            req_valid    <= 1'b1;
            req_drain    <= word.drain;
            req_pixel_in <= word.pixel;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus an occasional long hold-off counted here.
   always @(negedge clock) begin : receiver
      if (hold_served != hold_requests) begin
         hold_served   <= hold_requests;
         rsp_hold_left <= hold_length;
         rsp_ready     <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_ready     <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_word(input logic drain, input logic [PIXEL_BITS-1:0] pixel);
      raster_word_t word;
      word.drain = drain;
      word.pixel = pixel;
      words_to_send.push_back(word);
      words_queued++;
   endtask

   function automatic logic [PIXEL_BITS-1:0] pick_pixel(input texture_t texture,
                                                        input logic [PIXEL_BITS-1:0] base);
      case (texture)
         TEXTURE_NOISE:  return 8'($urandom_range(255));
         TEXTURE_SMOOTH: return base + 8'($urandom_range(15));
         default:        return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      endcase
   endfunction

   // Queues data pixels in raster order. With drain_pct above zero a drain
   // word now and then cuts into the frame, which sends the oldest held pixel
   // as it is and leaves a gap in the results until the window refills.
   task automatic queue_pixels(input int count, input texture_t texture, input int drain_pct);
      logic [PIXEL_BITS-1:0] base;
      base = 8'($urandom_range(255));
      repeat (count) begin
         if ($urandom_range(99) < drain_pct) queue_word(1'b1, 8'($urandom_range(255)));
         queue_word(1'b0, pick_pixel(texture, base));
         gen_frame_pos = (gen_frame_pos + 1) % (active_width() * active_height());
      end
   endtask

   // Completes the frame in progress and flushes the W+1 held pixels. Now and
   // then one more drain follows, which must produce nothing.
   task automatic finish_frame(input texture_t texture);
      int left;
      left = (gen_frame_pos == 0) ? 0 : active_width() * active_height() - gen_frame_pos;
      queue_pixels(left, texture, 0);
      repeat (active_width() + 1) queue_word(1'b1, 8'($urandom_range(255)));
      if ($urandom_range(3) == 0) queue_word(1'b1, 8'($urandom_range(255)));
   endtask

   // Waits until every queued word is in and every result is out, then lets
   // the pipeline run empty behind words that caused no result.
   task automatic wait_idle();
      do @(negedge clock);
      while (words_accepted != words_queued || marked_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [DIM_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(negedge clock);
      while (!csr_fired);
      csr_valid <= 1'b0;
   endtask

   task automatic set_frame(input logic [DIM_BITS-1:0] width, input logic [DIM_BITS-1:0] height,
                            input logic [THR_BITS-1:0] threshold);
      write_reg(CSR_FRAME_WIDTH, width);
      write_reg(CSR_FRAME_HEIGHT, height);
      write_reg(CSR_EDGE_THRESHOLD, {4'b0, threshold});
   endtask

   task automatic apply_flow(input flow_t flow);
      case (flow)
         FLOW_FREE:            begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         FLOW_SENDER_GAPS:     begin send_idle_pct = 56; rsp_stall_pct = 0;  end
         FLOW_RECEIVER_STALLS: begin send_idle_pct = 0;  rsp_stall_pct = 56; end
         default:              begin send_idle_pct = 8;  rsp_stall_pct = 8;  end
      endcase
   endtask

   function automatic logic [THR_BITS-1:0] pick_threshold();
      case ($urandom_range(4))
         0:       return '0;
         1:       return '1;
         2:       return 8'($urandom_range(20));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int                  i, phase, frames, drain_pct;
      int unsigned         directed_words;
      logic [DIM_BITS-1:0] width, height;
      texture_t            texture;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed part. Width and height of zero must clamp to 3x3, and the
      // threshold is left at its reset value for the first frame.
      apply_flow(FLOW_FREE);
      write_reg(CSR_FRAME_WIDTH, '0);
      write_reg(CSR_FRAME_HEIGHT, '0);
      for (i = 0; i < 9; i++) queue_word(1'b0, SHARP_FRAME[i]);
      finish_frame(TEXTURE_NOISE);
      queue_word(1'b1, 8'hFF);          // drain with nothing held

      // Highest threshold: a gradient exactly on the limit is not an edge.
      wait_idle();
      write_reg(CSR_EDGE_THRESHOLD, 12'(8'hFF));
      for (i = 0; i < 9; i++) queue_word(1'b0, LIMIT_FRAME[i]);
      finish_frame(TEXTURE_NOISE);
      directed_words = words_queued;

      // Random part: small frames, cycling through the flow-control modes.
      phase = 0;
      while (words_queued < directed_words + RANDOM_WORDS) begin
         wait_idle();
         apply_flow(flow_t'(phase % 4));
         texture = texture_t'($urandom_range(2));
         if (phase == 2) begin
            // The receiver holds off for a long stretch while the sender
            // keeps offering a whole frame, so the pipeline fills and the
            // input stalls.
            set_frame(12'd8, 12'd8, 8'd40);
            hold_length   = LONG_HOLD_CYCLES;
            hold_requests = hold_requests + 1;
            queue_pixels(64, TEXTURE_NOISE, 0);
            finish_frame(TEXTURE_NOISE);
         end else if (phase == 5) begin
            // The sender stops halfway through a frame until every result
            // so far has come out, then finishes the frame.
            set_frame(12'd10, 12'd5, pick_threshold());
            queue_pixels(23, texture, 0);
            wait_idle();
            finish_frame(texture);
         end else begin
            width  = ($urandom_range(7) == 0) ? 12'($urandom_range(2))
                                              : 12'($urandom_range(14, 3));
            height = ($urandom_range(7) == 0) ? 12'($urandom_range(2))
                                              : 12'($urandom_range(7, 3));
            set_frame(width, height, pick_threshold());
            // One to three frames run back to back with no flush between them.
            frames    = $urandom_range(3, 1);
            drain_pct = ($urandom_range(1) != 0) ? 3 : 0;
            repeat (frames)
               queue_pixels(active_width() * active_height(), texture, drain_pct);
            finish_frame(texture);
         end
         phase++;
      end

      // Largest sizes, once each: an oversize width that clamps to the line
      // store depth, and the tallest frame on the narrowest width.
      wait_idle();
      apply_flow(FLOW_BOTH);
      set_frame(12'hFFF, 12'd3, 8'd12);
      queue_pixels(active_width() * active_height(), TEXTURE_BINARY, 0);
      finish_frame(TEXTURE_BINARY);
      wait_idle();
      set_frame(12'd3, 12'hFFF, 8'd30);
      queue_pixels(active_width() * active_height(), TEXTURE_NOISE, 0);
      finish_frame(TEXTURE_NOISE);
      phase += 2;

      wait_idle();
      $display("Sent %0d words in %0d phases; checked %0d results over %0d frames.",
               words_accepted, phase, results_checked, frames_seen);
      $display("Frames ran from clamped 3x3 to 2048x3 and 3x4095, with drains and stalls.");
      if (mismatch_count == 0 && marked_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin : watchdog
      #5_000_000;
      $display("Timeout with %0d results outstanding", marked_due.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
sv/sedge_pkg.sv
sv/sedge_line_store.sv
sv/sobel_edge_threshold.sv
test/sobel_edge_threshold_tb.sv
